@@ rtl/core/bcdts_pkg.sv @@
package bcdts_pkg;

   // Command codes carried on the input channel.
   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Key codes that the controller reacts to.
   localparam logic [7:0] KEY_UP    = 8'h19;
   localparam logic [7:0] KEY_DOWN  = 8'h18;
   localparam logic [7:0] KEY_LEFT  = 8'h17;
   localparam logic [7:0] KEY_RIGHT = 8'h16;
   localparam logic [7:0] KEY_ENTER = 8'h0D;
   localparam logic [7:0] KEY_ESC   = 8'h1B;

   // Field selection codes.
   localparam logic [1:0] FIELD_IDLE   = 2'd0;
   localparam logic [1:0] FIELD_HOUR   = 2'd1;
   localparam logic [1:0] FIELD_MINUTE = 2'd2;
   localparam logic [1:0] FIELD_SECOND = 2'd3;

   // Wrap points of the BCD step.
   localparam logic [7:0] HOUR_WRAP_UP    = 8'h24;
   localparam logic [7:0] MINSEC_WRAP_UP  = 8'h60;
   localparam logic [7:0] WRAP_DOWN       = 8'hF9;
   localparam logic [7:0] HOUR_MAX        = 8'h23;
   localparam logic [7:0] MINSEC_MAX      = 8'h59;

   // One BCD increment with wrap at 24 or 60.
   function automatic logic [7:0] bcd_up(input logic [7:0] value, input logic is_hour);
      logic [7:0] r;
      r = value + 8'd1;
      if (r[3:0] == 4'hA) begin
         r = {r[7:4] + 4'd1, 4'h0};
      end
      if (r == (is_hour ? HOUR_WRAP_UP : MINSEC_WRAP_UP)) begin
         r = 8'h00;
      end
      return r;
   endfunction

   // One BCD decrement with wrap below zero.
   function automatic logic [7:0] bcd_down(input logic [7:0] value, input logic is_hour);
      logic [7:0] r;
      r = value - 8'd1;
      if (r[3:0] == 4'hF) begin
         r = {r[7:4], 4'h9};
      end
      if (r == WRAP_DOWN) begin
         r = is_hour ? HOUR_MAX : MINSEC_MAX;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/bcd_clock_time_setter_unit.sv @@
// A request passes through the input register and then the response register before it
// shows on the response port. Throughput: one request per cycle while no response is
// stalled. While a response is stalled, the input register takes one more request,
// and then req_stall rises until the response leaves.
// Reset (synchronous, active high) clears both valid flags, selects the idle field,
// clears the cursor and sets the buffered hour, minute and second to zero.
module bcd_clock_time_setter_unit
   import bcdts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_key_code,
   input  logic [7:0] req_live_hour,
   input  logic [7:0] req_live_minute,
   input  logic [7:0] req_live_second,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_hour_bcd,
   output logic [7:0] rsp_minute_bcd,
   output logic [7:0] rsp_second_bcd,
   output logic [1:0] rsp_set_field,
   output logic       rsp_cursor_on,
   output logic       rsp_save_strobe
);

   // Input register stage. It holds one request until the state update
   // stage can take it.
   logic       in_valid_ff;
   logic       in_cmd_ff;
   logic [7:0] in_key_ff;
   logic [7:0] in_hour_ff;
   logic [7:0] in_minute_ff;
   logic [7:0] in_second_ff;

   // Controller state. The response payload is read straight from these
   // registers, since they change only when a new response is loaded.
   logic [1:0] field_ff,  field_in;
   logic [7:0] hour_ff,   hour_in;
   logic [7:0] minute_ff, minute_in;
   logic [7:0] second_ff, second_in;
   logic       cursor_ff, cursor_in;
   logic       save_ff,   save_in;
   logic       out_valid_ff;

   logic out_move;
   logic in_load;

   // The response register is free when it is empty or its response is
   // being taken in this cycle; the held request then moves into it.
   assign out_move  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_move;
   assign in_load   = req_valid && !req_stall;

   // Next state for the request that sits in the input register.
   always_comb begin
      field_in  = field_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      cursor_in = cursor_ff;
      save_in   = 1'b0;
      if (in_cmd_ff == CMD_LOAD) begin
         // Live bytes are copied as given, valid BCD or not.
         hour_in   = in_hour_ff;
         minute_in = in_minute_ff;
         second_in = in_second_ff;
      end else begin
         case (in_key_ff)
            KEY_UP, KEY_DOWN: begin
               case (field_ff)
                  FIELD_HOUR: begin
                     hour_in = (in_key_ff == KEY_UP) ? bcd_up(hour_ff, 1'b1)
                                                     : bcd_down(hour_ff, 1'b1);
                  end
                  FIELD_MINUTE: begin
                     minute_in = (in_key_ff == KEY_UP) ? bcd_up(minute_ff, 1'b0)
                                                       : bcd_down(minute_ff, 1'b0);
                  end
                  FIELD_SECOND: begin
                     second_in = (in_key_ff == KEY_UP) ? bcd_up(second_ff, 1'b0)
                                                       : bcd_down(second_ff, 1'b0);
                  end
                  default: begin
                  end
               endcase
            end
            KEY_LEFT: begin
               // Rotation only applies while a field is selected.
               if (field_ff != FIELD_IDLE) begin
                  field_in = (field_ff == FIELD_HOUR) ? FIELD_SECOND : field_ff - 2'd1;
               end
            end
            KEY_RIGHT: begin
               if (field_ff != FIELD_IDLE) begin
                  field_in = (field_ff == FIELD_SECOND) ? FIELD_HOUR : field_ff + 2'd1;
               end
            end
            KEY_ENTER: begin
               // Enter either starts setting on the hour, or leaves and saves.
               if (field_ff == FIELD_IDLE) begin
                  field_in  = FIELD_HOUR;
                  cursor_in = 1'b1;
               end else begin
                  field_in  = FIELD_IDLE;
                  cursor_in = 1'b0;
                  save_in   = 1'b1;
               end
            end
            KEY_ESC: begin
               field_in  = FIELD_IDLE;
               cursor_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (out_move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_cmd_ff    <= req_cmd;
         in_key_ff    <= req_key_code;
         in_hour_ff   <= req_live_hour;
         in_minute_ff <= req_live_minute;
         in_second_ff <= req_live_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         field_ff     <= FIELD_IDLE;
         hour_ff      <= 8'h00;
         minute_ff    <= 8'h00;
         second_ff    <= 8'h00;
         cursor_ff    <= 1'b0;
      end else begin
         if (out_move) begin
            out_valid_ff <= 1'b1;
            field_ff     <= field_in;
            hour_ff      <= hour_in;
            minute_ff    <= minute_in;
            second_ff    <= second_in;
            cursor_ff    <= cursor_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_move) begin
         save_ff <= save_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_hour_bcd    = hour_ff;
   assign rsp_minute_bcd  = minute_ff;
   assign rsp_second_bcd  = second_ff;
   assign rsp_set_field   = field_ff;
   assign rsp_cursor_on   = cursor_ff;
   assign rsp_save_strobe = save_ff;

`ifndef SYNTH
   // The cursor is shown exactly while some field is selected.
   a_cursor_tracks_field: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == (field_ff != FIELD_IDLE))
      else $error("cursor flag disagrees with field selection");

   // A save request always leaves setting mode.
   a_save_leaves_setting: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && save_ff) |-> (field_ff == FIELD_IDLE && !cursor_ff))
      else $error("save strobe while still in setting mode");

   // A load transfer copies the live hour into the buffer.
   a_load_copies_hour: assert property (@(posedge clock) disable iff (reset)
      (out_move && in_cmd_ff == CMD_LOAD) |=> (hour_ff == $past(in_hour_ff)))
      else $error("load did not copy the live hour");

   // The input stage never drops a held request.
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_move) |=> in_valid_ff)
      else $error("held request lost");
`endif

endmodule

@@ dv/bcd_clock_time_setter_unit_test.sv @@
`timescale 1ns / 1ps

module bcd_clock_time_setter_unit_test
   import bcdts_pkg::*;
();

   // The receiver holds off for this many cycles in the pressure test. The block
   // buffers only a couple of requests, so the sender runs into a stalled input.
   localparam int HOLD_OFF_CYCLES = 64;
   // Drain window at the end of the run and the overall run limit in ns.
   localparam int DRAIN_CYCLES    = 20000;
   localparam int RUN_LIMIT_NS    = 4000000;
   localparam int RANDOM_ITEMS    = 1000;

   // One response as the block shows it after a request.
   typedef struct packed {
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
      logic [1:0] field;
      logic       cursor;
      logic       save;
   } clock_view_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic       req_cmd         = CMD_KEY;
   logic [7:0] req_key_code    = 8'h00;
   logic [7:0] req_live_hour   = 8'h00;
   logic [7:0] req_live_minute = 8'h00;
   logic [7:0] req_live_second = 8'h00;

   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_hour_bcd;
   logic [7:0] rsp_minute_bcd;
   logic [7:0] rsp_second_bcd;
   logic [1:0] rsp_set_field;
   logic       rsp_cursor_on;
   logic       rsp_save_strobe;

   // Predicted state of the controller, updated on every request transfer.
   logic [1:0] model_field  = FIELD_IDLE;
   logic [7:0] model_hour   = 8'h00;
   logic [7:0] model_minute = 8'h00;
   logic [7:0] model_second = 8'h00;
   logic       model_cursor = 1'b0;

   // Responses that the block still owes, oldest first.
   clock_view_type pending_views[$];

   int  error_count   = 0;
   int  items_sent    = 0;
   bit  source_gaps_on = 1'b1;
   bit  sink_gaps_on   = 1'b1;
   bit  hold_off_req   = 1'b0;

   bcd_clock_time_setter_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key_code    (req_key_code),
      .req_live_hour   (req_live_hour),
      .req_live_minute (req_live_minute),
      .req_live_second (req_live_second),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hour_bcd    (rsp_hour_bcd),
      .rsp_minute_bcd  (rsp_minute_bcd),
      .rsp_second_bcd  (rsp_second_bcd),
      .rsp_set_field   (rsp_set_field),
      .rsp_cursor_on   (rsp_cursor_on),
      .rsp_save_strobe (rsp_save_strobe)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 9);
      end
      return $urandom_range(10, 40);
   endfunction

   // BCD increment of one time field. The carry out of the low digit is done
   // by clearing the nibble and adding one to the upper digit.
   function automatic logic [7:0] bcd_increment(input logic [7:0] value, input bit is_hour);
      logic [7:0] sum;
      sum = value + 8'h01;
      if (sum[3:0] == 4'hA) begin
         sum = {sum[7:4], 4'h0} + 8'h10;
      end
      if (is_hour && sum == HOUR_WRAP_UP) begin
         sum = 8'h00;
      end else if (!is_hour && sum == MINSEC_WRAP_UP) begin
         sum = 8'h00;
      end
      return sum;
   endfunction

   // BCD decrement of one time field; a borrow sets the low digit to nine and
   // stepping below zero lands on the top of the range.
   function automatic logic [7:0] bcd_decrement(input logic [7:0] value, input bit is_hour);
      logic [7:0] diff;
      diff = value - 8'h01;
      if (diff[3:0] == 4'hF) begin
         diff[3:0] = 4'h9;
      end
      if (diff == WRAP_DOWN) begin
         diff = is_hour ? HOUR_MAX : MINSEC_MAX;
      end
      return diff;
   endfunction

   // Applies one request to the predicted state and returns the view that the
   // block must show for it.
   function automatic clock_view_type advance_setter(input logic cmd, input logic [7:0] key,
                                                     input logic [7:0] hour_in,
                                                     input logic [7:0] minute_in,
                                                     input logic [7:0] second_in);
      clock_view_type view;
      logic           save;
      bit             step_up;
      save = 1'b0;
      if (cmd == CMD_LOAD) begin
         // The live bytes are taken as they are, valid BCD or not.
         model_hour   = hour_in;
         model_minute = minute_in;
         model_second = second_in;
      end else if (key == KEY_UP || key == KEY_DOWN) begin
         step_up = (key == KEY_UP);
         case (model_field)
            FIELD_HOUR: begin
               model_hour = step_up ? bcd_increment(model_hour, 1'b1)
                                    : bcd_decrement(model_hour, 1'b1);
            end
            FIELD_MINUTE: begin
               model_minute = step_up ? bcd_increment(model_minute, 1'b0)
                                      : bcd_decrement(model_minute, 1'b0);
            end
            FIELD_SECOND: begin
               model_second = step_up ? bcd_increment(model_second, 1'b0)
                                      : bcd_decrement(model_second, 1'b0);
            end
            default: begin
            end
         endcase
      end else if (key == KEY_LEFT) begin
         if (model_field != FIELD_IDLE) begin
            model_field = (model_field == FIELD_HOUR) ? FIELD_SECOND : model_field - 2'd1;
         end
      end else if (key == KEY_RIGHT) begin
         if (model_field != FIELD_IDLE) begin
            model_field = (model_field == FIELD_SECOND) ? FIELD_HOUR : model_field + 2'd1;
         end
      end else if (key == KEY_ENTER) begin
         if (model_field == FIELD_IDLE) begin
            model_field  = FIELD_HOUR;
            model_cursor = 1'b1;
         end else begin
            model_field  = FIELD_IDLE;
            model_cursor = 1'b0;
            save         = 1'b1;
         end
      end else if (key == KEY_ESC) begin
         // Escape also clears the cursor when nothing was being set.
         model_field  = FIELD_IDLE;
         model_cursor = 1'b0;
      end
      view.hour   = model_hour;
      view.minute = model_minute;
      view.second = model_second;
      view.field  = model_field;
      view.cursor = model_cursor;
      view.save   = save;
      return view;
   endfunction

   // Every request transfer is predicted at the edge where it happens. The
   // values read here are the ones from before the edge, so the order of
   // processes within the time step does not matter.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_views.push_back(advance_setter(req_cmd, req_key_code, req_live_hour,
                                                req_live_minute, req_live_second));
      end
   end

   // Every response transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      clock_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_views.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_views.pop_front();
            if (rsp_hour_bcd !== want.hour) begin
               $error("hour_bcd: expected %h, actual %h", want.hour, rsp_hour_bcd);
               error_count++;
            end
            if (rsp_minute_bcd !== want.minute) begin
               $error("minute_bcd: expected %h, actual %h", want.minute, rsp_minute_bcd);
               error_count++;
            end
            if (rsp_second_bcd !== want.second) begin
               $error("second_bcd: expected %h, actual %h", want.second, rsp_second_bcd);
               error_count++;
            end
            if (rsp_set_field !== want.field) begin
               $error("set_field: expected %0d, actual %0d", want.field, rsp_set_field);
               error_count++;
            end
            if (rsp_cursor_on !== want.cursor) begin
               $error("cursor_on: expected %b, actual %b", want.cursor, rsp_cursor_on);
               error_count++;
            end
            if (rsp_save_strobe !== want.save) begin
               $error("save_strobe: expected %b, actual %b", want.save, rsp_save_strobe);
               error_count++;
            end
         end
      end
   end

   // Receiver. It stalls at random while sink gaps are on, and on request it
   // holds off for a long counted stretch. Exactly one assignment per edge.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            stall_left   = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end else if (stall_left == 0 && sink_gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request and returns once it has been transferred. With source
   // gaps on, valid may drop for a while afterwards; otherwise it stays high so
   // that the next call keeps the channel busy.
   task automatic send_request(input logic cmd, input logic [7:0] key,
                               input logic [7:0] hour_in, input logic [7:0] minute_in,
                               input logic [7:0] second_in);
      int gap;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_key_code    <= key;
      req_live_hour   <= hour_in;
      req_live_minute <= minute_in;
      req_live_second <= second_in;
      do begin
         @(posedge clock);
      end while (req_stall);
      items_sent++;
      gap = source_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A key request carries random bytes on the live fields, which must be ignored.
   task automatic send_key(input logic [7:0] key);
      send_request(CMD_KEY, key, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
   endtask

   task automatic send_load(input logic [7:0] hour_in, input logic [7:0] minute_in,
                            input logic [7:0] second_in);
      send_request(CMD_LOAD, 8'($urandom_range(0, 255)), hour_in, minute_in, second_in);
   endtask

   function automatic logic [7:0] random_bcd(input int top);
      int value;
      value = $urandom_range(0, top);
      return {4'(value / 10), 4'(value % 10)};
   endfunction

   // Navigation and step keys most of the time, other codes now and then.
   function automatic logic [7:0] pick_setting_key();
      case ($urandom_range(0, 11))
         0, 1, 2:  return KEY_UP;
         3, 4, 5:  return KEY_DOWN;
         6, 7:     return KEY_LEFT;
         8, 9:     return KEY_RIGHT;
         10:       return KEY_ESC;
         default:  return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Extremes of the fields, every key while idle and while setting, wraps in
   // both directions, invalid codes and the ignored key code of a load.
   task automatic test_directed();
      send_load(8'h00, 8'h00, 8'h00);
      send_key(KEY_UP);
      send_key(KEY_DOWN);
      send_key(KEY_LEFT);
      send_key(KEY_RIGHT);
      send_key(KEY_ESC);
      send_key(8'h00);
      send_key(8'hFF);
      send_key(8'h35);
      send_request(CMD_LOAD, KEY_ENTER, 8'h23, 8'h59, 8'h59);
      send_key(KEY_ENTER);
      send_key(KEY_UP);
      send_key(KEY_DOWN);
      send_key(KEY_RIGHT);
      send_key(KEY_UP);
      send_key(KEY_DOWN);
      send_key(KEY_LEFT);
      send_key(KEY_LEFT);
      send_key(KEY_UP);
      send_key(KEY_RIGHT);
      send_request(CMD_LOAD, KEY_UP, 8'hFF, 8'hFA, 8'h0F);
      send_key(KEY_UP);
      send_key(KEY_RIGHT);
      send_key(KEY_UP);
      send_key(KEY_RIGHT);
      send_key(KEY_DOWN);
      send_key(KEY_ESC);
      send_key(KEY_ENTER);
      send_key(KEY_ENTER);
   endtask

   // Mostly complete setting sessions with random content: an optional load,
   // Enter, a run of navigation and steps, then Enter or Escape. Between
   // sessions some noise goes in, both loads and arbitrary key codes.
   task automatic test_random_sessions(input int item_goal);
      int target;
      int steps;
      int roll;
      target = items_sent + item_goal;
      while (items_sent < target) begin
         roll = $urandom_range(0, 9);
         if (roll < 7) begin
            if ($urandom_range(0, 3) != 0) begin
               if ($urandom_range(0, 4) != 0) begin
                  send_load(random_bcd(23), random_bcd(59), random_bcd(59));
               end else begin
                  send_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
               end
            end
            send_key(KEY_ENTER);
            steps = $urandom_range(1, 14);
            repeat (steps) send_key(pick_setting_key());
            roll = $urandom_range(0, 19);
            if (roll < 10) begin
               send_key(KEY_ENTER);
            end else if (roll < 17) begin
               send_key(KEY_ESC);
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_request(CMD_LOAD, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
               end else begin
                  send_key(8'($urandom_range(0, 255)));
               end
            end
         end
      end
   endtask

   // A stretch with no idling on either side.
   task automatic test_back_to_back();
      source_gaps_on = 1'b0;
      sink_gaps_on   = 1'b0;
      test_random_sessions(120);
      source_gaps_on = 1'b1;
      sink_gaps_on   = 1'b1;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering requests back to back, so the block fills and stalls its input.
   task automatic test_receiver_hold_off();
      source_gaps_on = 1'b0;
      hold_off_req   = 1'b1;
      test_random_sessions(60);
      source_gaps_on = 1'b1;
   endtask

   // Waits for every outstanding response, then a few more cycles so that a
   // stray extra response would still be seen by the checker.
   task automatic drain_responses();
      int waited;
      waited = 0;
      while (pending_views.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      if (pending_views.size() != 0) begin
         $error("%0d responses never arrived", pending_views.size());
         error_count++;
      end
      repeat (10) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sessions(RANDOM_ITEMS / 2);
      test_receiver_hold_off();
      test_back_to_back();
      test_random_sessions(RANDOM_ITEMS / 2);
      req_valid <= 1'b0;
      drain_responses();
      if (error_count == 0) begin
         $display("bcd_clock_time_setter_unit_test: PASS");
      end else begin
         $display("bcd_clock_time_setter_unit_test: FAIL");
      end
      $finish;
   end

   // Hard limit in case a transfer never completes.
   initial begin
      #(RUN_LIMIT_NS);
      $display("bcd_clock_time_setter_unit_test: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/bcdts_pkg.sv
rtl/core/bcd_clock_time_setter_unit.sv
dv/bcd_clock_time_setter_unit_test.sv
